@@ rtl/spq_pkg.sv @@
// Package for the sorted priority queue: depth, codes, beat and cell link types.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
package spq_pkg;

    // Number of cells in the chain, and the width of a count of stored entries.
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Operation codes of an input beat; the unused code behaves as a peek.
    localparam logic [1:0] FUNC_OFFER = 2'd0;
    localparam logic [1:0] FUNC_POLL  = 2'd1;
    localparam logic [1:0] FUNC_PEEK  = 2'd2;

    // Status codes of a result beat.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Command beat.
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] priority_req;
        logic signed [31:0] value;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] polled_value;
        logic signed [31:0] head_value;
        logic               head_valid;
        logic [4:0]         count;
    } t_out_beat;

    // What every cell does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_OUT
    } t_cell_op;

    // Broadcast from the control to all cells.
    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] prio;
        logic signed [31:0] value;
    } t_cell_ctrl;

    // Contents of one cell.
    typedef struct packed {
        logic               valid;
        logic signed [31:0] prio;
        logic signed [31:0] value;
    } t_cell_data;

    // What a cell shows its neighbors: its contents and whether it keeps them on insert.
    typedef struct packed {
        logic       keep;
        t_cell_data data;
    } t_cell_link;

endpackage

@@ rtl/spq_cell.sv @@
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_cell_link i_left,
    input  spq_pkg::t_cell_data i_right,
    output spq_pkg::t_cell_link o_link
);
    import spq_pkg::*;

    logic               r_valid;
    logic signed [31:0] r_prio;
    logic signed [31:0] r_value;
    logic               n_valid;
    logic signed [31:0] n_prio;
    logic signed [31:0] n_value;
    logic               w_keep;

    // An entry stays put on insert when its priority is at least the new one.
    assign w_keep = r_valid && (r_prio >= i_ctrl.prio);

    // Next contents: keep, take the new entry, take the left entry, or take the right one.
    always_comb begin
        n_valid = r_valid;
        n_prio  = r_prio;
        n_value = r_value;
        unique case (i_ctrl.op)
            CELL_INSERT: begin
                if (!w_keep) begin
                    if (i_left.keep) begin
                        n_valid = 1'b1;
                        n_prio  = i_ctrl.prio;
                        n_value = i_ctrl.value;
                    end else begin
                        n_valid = i_left.data.valid;
                        n_prio  = i_left.data.prio;
                        n_value = i_left.data.value;
                    end
                end
            end
            CELL_SHIFT_OUT: begin
                n_valid = i_right.valid;
                n_prio  = i_right.prio;
                n_value = i_right.value;
            end
            default: begin
            end
        endcase
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio  <= n_prio;
        r_value <= n_value;
    end

    assign o_link.keep       = w_keep;
    assign o_link.data.valid = r_valid;
    assign o_link.data.prio  = r_prio;
    assign o_link.data.value = r_value;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: command decode, result register, cell chain.
// Depends on spq_pkg and spq_cell.
//
// Usage:
// A command beat (i_cmd) is taken at a rising edge where start is high and busy is
// low. busy stays low: the chain of cells finishes any command in a single
// compare-and-shift step, so a new command may be given in every cycle.
// func selects offer, poll or peek. An offer places the entry behind all stored
// entries of greater or equal priority; a poll removes the head entry.
// Every command gives one result beat on o_res, marked by o_done, in the cycle
// after the command was taken; throughput is one command per cycle, set by the
// single compare-and-shift step of the cells.
// The result holds status (ok, poll on empty, offer on full), the polled value,
// the head after the command and the count of stored entries.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset (synchronous, active low) empties the queue and clears o_done.
module sorted_priority_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::t_in_beat i_cmd,
    output logic              o_done,
    output spq_pkg::t_out_beat o_res
);
    import spq_pkg::*;

    t_cell_link         w_link [DEPTH];
    t_cell_ctrl         w_ctrl;
    t_cell_link         w_head_left;
    t_cell_data         w_tail_right;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;

    logic               r_done;
    logic [1:0]         r_status;
    logic signed [31:0] r_polled;
    logic [CNT_W-1:0]   r_count;
    logic               n_done;
    logic [1:0]         n_status;
    logic signed [31:0] n_polled;
    logic [CNT_W-1:0]   n_count;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = w_link[DEPTH-1].data.valid;
    assign w_empty  = !w_link[0].data.valid;

    // Decode the command into a cell operation and the result fields.
    always_comb begin
        w_ctrl.op    = CELL_HOLD;
        w_ctrl.prio  = i_cmd.priority_req;
        w_ctrl.value = i_cmd.value;
        n_done       = w_accept;
        n_status     = STATUS_OK;
        n_polled     = '0;
        n_count      = r_count;
        if (w_accept) begin
            case (i_cmd.func)
                FUNC_OFFER: begin
                    if (w_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        w_ctrl.op = CELL_INSERT;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                FUNC_POLL: begin
                    if (w_empty) begin
                        n_status = STATUS_EMPTY;
                    end else begin
                        w_ctrl.op = CELL_SHIFT_OUT;
                        n_polled  = w_link[0].data.value;
                        n_count   = r_count - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Ends of the chain: the head sees a left neighbor that always keeps,
    // the tail sees an empty right neighbor.
    always_comb begin
        w_head_left.keep       = 1'b1;
        w_head_left.data.valid = 1'b1;
        w_head_left.data.prio  = '0;
        w_head_left.data.value = '0;
        w_tail_right.valid     = 1'b0;
        w_tail_right.prio      = '0;
        w_tail_right.value     = '0;
    end

    // The chain of cells, head at index zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_left  (w_head_left),
                .i_right (w_link[g+1].data),
                .o_link  (w_link[g])
            );
        end else if (g == DEPTH - 1) begin : g_tail
            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_left  (w_link[g-1]),
                .i_right (w_tail_right),
                .o_link  (w_link[g])
            );
        end else begin : g_mid
            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_left  (w_link[g-1]),
                .i_right (w_link[g+1].data),
                .o_link  (w_link[g])
            );
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_polled <= n_polled;
    end

    // Result beat; the head comes straight from the first cell after the update.
    assign o_done             = r_done;
    assign o_res.status       = r_status;
    assign o_res.polled_value = r_polled;
    assign o_res.head_valid   = w_link[0].data.valid;
    assign o_res.head_value   = w_link[0].data.valid ? w_link[0].data.value : 32'sd0;
    assign o_res.count        = 5'(r_count);

    // The count agrees with the valid bits at both ends of the chain.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_empty == (r_count == '0))
        else $error("count and head valid bit disagree");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full == (r_count == CNT_W'(DEPTH)))
        else $error("count and tail valid bit disagree");

    // Valid entries stay packed toward the head.
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[DEPTH-1].data.valid |-> w_link[DEPTH-2].data.valid)
        else $error("gap in the cell chain");

    // A successful poll returns the head entry that was shown before it.
    a_poll_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == CELL_SHIFT_OUT) |=> (o_done && o_res.status == STATUS_OK
            && o_res.polled_value == $past(w_link[0].data.value)))
        else $error("polled value does not match the old head");

    // A result follows in the cycle after each accepted command.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("missing result beat");

endmodule

@@ dv/sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue: directed and phased random command beats.
// A tracker class predicts each result from its own sorted store. Depends on spq_pkg and the RTL.
module sorted_priority_queue_tb;

    import spq_pkg::*;

    // The unused operation code behaves as a peek.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1400;

    // Predicts every result from its own copy of the queue and checks the DUT against it.
    class spq_tracker;
        logic signed [31:0] prio_store [DEPTH];
        logic signed [31:0] value_store [DEPTH];
        int                 fill;
        t_out_beat          pending_results [$];
        int                 errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // Apply one accepted command beat to the store and queue up its result.
        function void note_command(t_in_beat cmd);
            t_out_beat res;
            int        pos;
            res        = '0;
            res.status = STATUS_OK;
            case (cmd.func)
                FUNC_OFFER: begin
                    if (fill >= DEPTH) begin
                        res.status = STATUS_FULL;
                    end else begin
                        // New entry goes behind every entry of greater or equal priority.
                        pos = 0;
                        while (pos < fill && prio_store[pos] >= cmd.priority_req)
                            pos++;
                        for (int i = fill; i > pos; i--) begin
                            prio_store[i]  = prio_store[i - 1];
                            value_store[i] = value_store[i - 1];
                        end
                        prio_store[pos]  = cmd.priority_req;
                        value_store[pos] = cmd.value;
                        fill++;
                    end
                end
                FUNC_POLL: begin
                    if (fill == 0) begin
                        res.status = STATUS_EMPTY;
                    end else begin
                        res.polled_value = value_store[0];
                        for (int i = 1; i < fill; i++) begin
                            prio_store[i - 1]  = prio_store[i];
                            value_store[i - 1] = value_store[i];
                        end
                        fill--;
                    end
                end
                default: begin
                end
            endcase
            res.head_valid = (fill > 0);
            res.head_value = (fill > 0) ? value_store[0] : 32'sd0;
            res.count      = 5'(fill);
            pending_results.push_back(res);
        endfunction

        // Compare one result beat, field by field, with the oldest prediction.
        function void check_result(t_out_beat got);
            t_out_beat want;
            if (pending_results.size() == 0) begin
                $error("result beat arrived with no prediction waiting");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.polled_value !== want.polled_value) begin
                $error("polled_value: expected %0d, got %0d", want.polled_value,
                       got.polled_value);
                errors++;
            end
            if (got.head_value !== want.head_value) begin
                $error("head_value: expected %0d, got %0d", want.head_value, got.head_value);
                errors++;
            end
            if (got.head_valid !== want.head_valid) begin
                $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_beat  i_cmd;
    logic      o_done;
    t_out_beat o_res;

    spq_tracker tracker;
    bit         idle_on;

    sorted_priority_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Watch both sides at the rising edge: check the result first, then note the new command.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                tracker.check_result(o_res);
            if (start && !busy)
                tracker.note_command(i_cmd);
        end
    end

    // Drive one command beat from a falling edge, with occasional idle cycles before it while idle_on is set.
    task automatic send_cmd(input logic [1:0] func, input logic signed [31:0] prio,
                            input logic signed [31:0] value);
        t_in_beat cmd;
        cmd.func         = func;
        cmd.priority_req = prio;
        cmd.value        = value;
        while (idle_on && $urandom_range(0, 99) < 6) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted result has been seen.
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (tracker.pending() > 0)
            @(negedge i_clk);
    endtask

    // Random priority: half the time a narrow band to force ties, sometimes the extremes, else any value.
    function automatic logic signed [31:0] pick_prio();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $signed($urandom_range(0, 7)) - 32'sd4;
        else if (r < 55)
            return 32'sh7fffffff;
        else if (r < 60)
            return 32'sh80000000;
        return $signed($urandom);
    endfunction

    // Operation mix depends on the phase: 0 fills, 1 drains, 2 is balanced.
    function automatic logic [1:0] pick_func(input int mode);
        int unsigned r;
        int          offer_pct;
        r         = $urandom_range(0, 99);
        offer_pct = (mode == 0) ? 65 : (mode == 1) ? 20 : 45;
        if (r < offer_pct)
            return FUNC_OFFER;
        else if (r < 85)
            return FUNC_POLL;
        else if (r < 97)
            return FUNC_PEEK;
        return FUNC_UNUSED;
    endfunction

    // Stimulus.
    initial begin
        logic signed [31:0] prio;
        logic signed [31:0] value;
        int                 sent;
        int                 phase;
        int                 len;
        int                 mode;

        tracker = new();
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty queue: poll error, peek, unused code.
        send_cmd(FUNC_POLL, 32'sd0, 32'sd0);
        send_cmd(FUNC_PEEK, 32'sd0, 32'sd0);
        send_cmd(FUNC_UNUSED, 32'sh7fffffff, 32'sh80000000);

        // Fill to capacity with extreme and repeated priorities, then offer once more on full.
        for (int i = 0; i <= DEPTH; i++) begin
            case (i % 4)
                0: prio = 32'sh7fffffff;
                1: prio = 32'sh80000000;
                2: prio = 32'sd0;
                default: prio = 32'sd7;
            endcase
            case (i)
                0: value = 32'sh7fffffff;
                1: value = 32'sh80000000;
                2: value = 32'sd0;
                3: value = -32'sd1;
                default: value = $signed(32'(i) * 32'h01010101);
            endcase
            send_cmd(FUNC_OFFER, prio, value);
        end
        send_cmd(FUNC_PEEK, 32'sd0, 32'sd0);
        send_cmd(FUNC_UNUSED, 32'sd0, 32'sd0);
        // Equal top priorities must leave in arrival order.
        repeat (3) send_cmd(FUNC_POLL, 32'sd0, 32'sd0);
        wait_drained();

        // Random phases that push the queue between empty and full.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BEATS) begin
            len     = $urandom_range(20, 80);
            mode    = $urandom_range(0, 2);
            // A long stretch without idle cycles.
            idle_on = !(phase >= 4 && phase <= 9);
            for (int k = 0; k < len; k++) begin
                send_cmd(pick_func(mode), pick_prio(), $signed($urandom));
                sent++;
            end
            if (phase % 5 == 4)
                wait_drained();
            phase++;
        end

        // Let the last results come out, then keep the clock running for stray beats.
        wait_drained();
        repeat (4) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #400us;
        $display("status: fail");
        $finish;
    end

endmodule

@@ sorted_priority_queue.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
dv/sorted_priority_queue_tb.sv
